FILE: hdl/mlse_pkg.sv
`default_nettype none

package mlse_pkg;

  // Sizing
  localparam int NUM_STACKS  = 10;
  localparam int POOL_DEPTH  = 256;
  localparam int QUEUE_DEPTH = 2;

  // Widths of the item fields
  localparam int FIELD_W  = 16;
  localparam int SID_IN_W = 4;
  localparam int STAT_W   = 2;
  localparam int REC_W    = 3 * FIELD_W;

  // Node address, node pointer (with null code), stack index
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // Queue pointer and fill count
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_DEPTH);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_BAD_PUSH = 2'd2,
    CMD_BAD_POP  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [SW-1:0]     sid;
    logic [REC_W-1:0]  rec;
  } cmd_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_COMMIT = 1'b1
  } back_state_e;

endpackage

`default_nettype wire

FILE: hdl/mlse_if.sv
`default_nettype none

// Request channel
interface mlse_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [mlse_pkg::SID_IN_W-1:0] stack_id;
  logic [mlse_pkg::FIELD_W-1:0]  subject_in;
  logic [mlse_pkg::FIELD_W-1:0]  class_in;
  logic [mlse_pkg::FIELD_W-1:0]  score_in;

  modport source (
    output valid, action, stack_id, subject_in, class_in, score_in,
    input  ready
  );
  modport sink (
    input  valid, action, stack_id, subject_in, class_in, score_in,
    output ready
  );
endinterface

// Response channel
interface mlse_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mlse_pkg::STAT_W-1:0]  status;
  logic [mlse_pkg::FIELD_W-1:0] subject_out;
  logic [mlse_pkg::FIELD_W-1:0] class_out;
  logic [mlse_pkg::FIELD_W-1:0] score_out;

  modport source (
    output valid, status, subject_out, class_out, score_out,
    input  ready
  );
  modport sink (
    input  valid, status, subject_out, class_out, score_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/mlse_front.sv
`default_nettype none

module mlse_front (
  mlse_req_if.sink          req_i,
  output logic              cmd_valid_o,
  input  wire               cmd_ready_i,
  output mlse_pkg::cmd_t    cmd_o
);

  logic sid_ok;

  always_comb begin
    sid_ok = 32'(req_i.stack_id) < mlse_pkg::NUM_STACKS;
    cmd_o.rec = {req_i.subject_in, req_i.class_in, req_i.score_in};
    // out-of-range stacks are resolved here; back end never indexes them
    cmd_o.sid = sid_ok ? mlse_pkg::SW'(req_i.stack_id) : '0;
    if (req_i.action == mlse_pkg::ACT_POP) begin
      cmd_o.op = sid_ok ? mlse_pkg::CMD_POP : mlse_pkg::CMD_BAD_POP;
    end else begin
      cmd_o.op = sid_ok ? mlse_pkg::CMD_PUSH : mlse_pkg::CMD_BAD_PUSH;
    end
  end

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

endmodule

`default_nettype wire

FILE: hdl/mlse_queue.sv
`default_nettype none

module mlse_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  mlse_pkg::cmd_t    push_cmd_i,
  output logic              pop_valid_o,
  input  wire               pop_ready_i,
  output mlse_pkg::cmd_t    pop_cmd_o
);

  mlse_pkg::cmd_t              slot_q [mlse_pkg::QUEUE_DEPTH];
  logic [mlse_pkg::QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mlse_pkg::QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mlse_pkg::QCW-1:0]    count_q, count_d;
  logic                        do_push, do_pop;

  assign push_ready_o = count_q != mlse_pkg::QCW'(mlse_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == mlse_pkg::QAW'(mlse_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == mlse_pkg::QAW'(mlse_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mlse_back.sv
`default_nettype none

module mlse_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cmd_valid_i,
  output logic              cmd_ready_o,
  input  mlse_pkg::cmd_t    cmd_i,
  mlse_rsp_if.source        rsp_o
);

  // Node pool
  logic [mlse_pkg::REC_W-1:0] rec_mem  [mlse_pkg::POOL_DEPTH];
  logic [mlse_pkg::PW-1:0]    next_mem [mlse_pkg::POOL_DEPTH];
  logic [mlse_pkg::REC_W-1:0] rd_rec_q;
  logic [mlse_pkg::PW-1:0]    rd_next_q;
  logic                       rd_en;
  logic [mlse_pkg::AW-1:0]    rd_addr;
  logic                       rec_we, next_we;
  logic [mlse_pkg::AW-1:0]    wr_addr;
  logic [mlse_pkg::PW-1:0]    wr_next;

  // List heads
  logic [mlse_pkg::PW-1:0] stack_top_q [mlse_pkg::NUM_STACKS];
  logic [mlse_pkg::PW-1:0] stack_top_d [mlse_pkg::NUM_STACKS];
  logic [mlse_pkg::PW-1:0] free_head_q, free_head_d;
  logic [mlse_pkg::PW-1:0] fresh_q, fresh_d;

  // Item in flight
  mlse_pkg::back_state_e   state_q, state_d;
  mlse_pkg::cmd_t          cmd_q, cmd_d;
  logic [mlse_pkg::PW-1:0] node_q, node_d;
  logic                    from_free_q, from_free_d;
  mlse_pkg::status_e       stat_q, stat_d;

  // Output register
  logic                       out_valid_q, out_valid_d;
  mlse_pkg::status_e          out_stat_q, out_stat_d;
  logic [mlse_pkg::REC_W-1:0] out_rec_q, out_rec_d;

  logic                    out_free;
  logic [mlse_pkg::PW-1:0] top_sel;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = state_q == mlse_pkg::BK_IDLE;
  assign top_sel     = stack_top_q[cmd_i.sid];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    node_d      = node_q;
    from_free_d = from_free_q;
    stat_d      = stat_q;
    stack_top_d = stack_top_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_rec_d   = out_rec_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rec_we      = 1'b0;
    next_we     = 1'b0;
    wr_addr     = node_q[mlse_pkg::AW-1:0];
    wr_next     = free_head_q;

    case (state_q)
      mlse_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d       = cmd_i;
          state_d     = mlse_pkg::BK_COMMIT;
          from_free_d = 1'b0;
          stat_d      = mlse_pkg::ST_OK;
          case (cmd_i.op)
            mlse_pkg::CMD_PUSH: begin
              if (free_head_q != mlse_pkg::NULL_PTR) begin
                // reuse freed node; fetch its link for the new free head
                node_d      = free_head_q;
                from_free_d = 1'b1;
                rd_en       = 1'b1;
                rd_addr     = free_head_q[mlse_pkg::AW-1:0];
              end else if (fresh_q < mlse_pkg::NULL_PTR) begin
                node_d = fresh_q;
              end else begin
                stat_d = mlse_pkg::ST_FULL;
              end
            end
            mlse_pkg::CMD_POP: begin
              node_d = top_sel;
              if (top_sel == mlse_pkg::NULL_PTR) begin
                stat_d = mlse_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = top_sel[mlse_pkg::AW-1:0];
              end
            end
            mlse_pkg::CMD_BAD_PUSH: stat_d = mlse_pkg::ST_FULL;
            mlse_pkg::CMD_BAD_POP:  stat_d = mlse_pkg::ST_EMPTY;
            default:                stat_d = mlse_pkg::ST_EMPTY;
          endcase
        end
      end
      mlse_pkg::BK_COMMIT: begin
        if (out_free) begin
          state_d     = mlse_pkg::BK_IDLE;
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_rec_d   = '0;
          if (stat_q == mlse_pkg::ST_OK) begin
            if (cmd_q.op == mlse_pkg::CMD_POP) begin
              out_rec_d                = rd_rec_q;
              stack_top_d[cmd_q.sid]   = rd_next_q;
              next_we                  = 1'b1;
              wr_next                  = free_head_q;
              free_head_d              = node_q;
            end else begin
              rec_we                   = 1'b1;
              next_we                  = 1'b1;
              wr_next                  = stack_top_q[cmd_q.sid];
              stack_top_d[cmd_q.sid]   = node_q;
              if (from_free_q) begin
                free_head_d = rd_next_q;
              end else begin
                fresh_d = fresh_q + 1'b1;
              end
            end
          end
        end
      end
      default: state_d = mlse_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlse_pkg::BK_IDLE;
      stack_top_q <= '{default: mlse_pkg::NULL_PTR};
      free_head_q <= mlse_pkg::NULL_PTR;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stack_top_q <= stack_top_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    node_q      <= node_d;
    from_free_q <= from_free_d;
    stat_q      <= stat_d;
    out_stat_q  <= out_stat_d;
    out_rec_q   <= out_rec_d;
  end

  // Pool memories: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_rec_q  <= rec_mem[rd_addr];
      rd_next_q <= next_mem[rd_addr];
    end
    if (rec_we) begin
      rec_mem[wr_addr] <= cmd_q.rec;
    end
    if (next_we) begin
      next_mem[wr_addr] <= wr_next;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.subject_out = out_rec_q[3*mlse_pkg::FIELD_W-1:2*mlse_pkg::FIELD_W];
  assign rsp_o.class_out   = out_rec_q[2*mlse_pkg::FIELD_W-1:mlse_pkg::FIELD_W];
  assign rsp_o.score_out   = out_rec_q[mlse_pkg::FIELD_W-1:0];

`ifndef SYNTHESIS
  // free list only holds nodes that were handed out before
  a_free_head_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == mlse_pkg::NULL_PTR) || (free_head_q < fresh_q))
    else $error("free head points past handed-out region");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= mlse_pkg::NULL_PTR)
    else $error("fresh count beyond pool");

  a_rsp_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mlse_pkg::BK_COMMIT))
    else $error("response without commit");

  a_pop_top_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlse_pkg::BK_COMMIT && stat_q == mlse_pkg::ST_OK &&
     cmd_q.op == mlse_pkg::CMD_POP) |-> (stack_top_q[cmd_q.sid] == node_q))
    else $error("stack top moved under pending pop");
`endif

endmodule

`default_nettype wire

FILE: hdl/multi_linked_stack_engine.sv
`default_nettype none

// Multiple linked stacks over one shared node pool. Requests come in on req_i:
// action 0 pushes the {subject, class, score} record onto stack stack_id,
// action 1 pops that stack's top record. Each request yields exactly one
// response on rsp_o, in request order: status OK (pop returns the record,
// push returns zeros), EMPTY for a pop of an empty or out-of-range stack, or
// FULL for a push with the pool exhausted or an out-of-range stack; record
// fields are zero unless a pop succeeds. Nodes are reused from a free list
// before untouched pool entries are handed out. The back end takes one item at a
// time: it does a registered read of the node pool (top node for a pop,
// free-list link for a push that reuses a node), then writes back the node
// and list heads, and only then accepts the next item from the queue. A
// response held by the sink stalls the write-back until the output register
// is free. A 2-entry command queue between the front end and back end plus
// the output register let requests keep coming while a response waits. No
// clearing pass after reset; items are accepted as soon as reset is released.
module multi_linked_stack_engine (
  input  wire          clk_i,
  input  wire          rst_ni,
  mlse_req_if.sink     req_i,
  mlse_rsp_if.source   rsp_o
);

  // front end -> queue
  logic            fe_valid;
  logic            fe_ready;
  mlse_pkg::cmd_t  fe_cmd;

  // queue -> back end
  logic            be_valid;
  logic            be_ready;
  mlse_pkg::cmd_t  be_cmd;

  // Decode and range-check the request
  mlse_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  // Decouples acceptance from execution
  mlse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_cmd_o    (be_cmd)
  );

  // Stack heads, free list and node pool; owns the response register
  mlse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
